@@ design/dvgb_pkg.sv @@
// Package for the detection velocity gate buffer.
// Holds the sequencer state type, multiply step codes, status codes and constants.
// Depends on nothing; imported by detection_velocity_gate_buffer.
`timescale 1ns / 1ps
`default_nettype none

package dvgb_pkg;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  // Multiply steps in issue order.
  typedef enum logic [2:0] {
    OP_VD = 3'd0,
    OP_DX = 3'd1,
    OP_DY = 3'd2,
    OP_LL = 3'd3,
    OP_LH = 3'd4,
    OP_HH = 3'd5,
    OP_KL = 3'd6,
    OP_KH = 3'd7
  } mul_op_t;

  localparam logic [3:0] MUL_STEPS = 4'd8;

  typedef enum logic [1:0] {
    REG_MAX_SPEED   = 2'd0,
    REG_HALF_LENGTH = 2'd1,
    REG_HALF_WIDTH  = 2'd2
  } cfg_reg_t;

  localparam logic [2:0] STAT_EMPTY   = 3'd0;
  localparam logic [2:0] STAT_STORED  = 3'd1;
  localparam logic [2:0] STAT_OUTSIDE = 3'd2;
  localparam logic [2:0] STAT_STALE   = 3'd3;
  localparam logic [2:0] STAT_NOISE   = 3'd4;

  // Ten to the twelfth power split at bit 32.
  localparam logic [31:0] TERA_LO = 32'hD4A5_1000;
  localparam logic [31:0] TERA_HI = 32'h0000_00E8;

  localparam logic [15:0] RST_MAX_SPEED   = 16'd8000;
  localparam logic [13:0] RST_HALF_LENGTH = 14'd6500;
  localparam logic [13:0] RST_HALF_WIDTH  = 14'd5000;

  localparam int ACC_W = 98;

endpackage

`default_nettype wire

@@ design/detection_velocity_gate_buffer.sv @@
// Detection velocity gate buffer: field test, stale test and speed gate over a store
// of recent detections, with one shared 32 x 32 multiplier under a step sequencer.
// Depends on dvgb_pkg.
//
//  Channel  Direction  Handshake           Payload
//  in_      slave      in_tvalid/in_tready in_tdata: pos_x, pos_y, stamp_us
//  out_     master     out_tvalid/out_tready out_tdata: status, fill_count
//  cfg_     write      cfg_we              cfg_addr, cfg_wdata
//
// One detection passes through the scan, check, speed test, decide and output states;
// the speed test runs only for an in-field, non-stale detection with a stored match.
// The scan reads one store entry a cycle; the speed test is eight products on the
// shared multiplier. in_tready is high only while idle.
// rst_n is synchronous; it clears the valid bits and restores the register defaults.
// The result is held in out_tdata until its transfer completes.
`timescale 1ns / 1ps
`default_nettype none

module detection_velocity_gate_buffer
  import dvgb_pkg::*;
#(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // pos_x[14:0], pos_y[29:15], stamp_us[61:30]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // status[2:0], fill_count[7:3]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [IW:0] SCAN_END = (IW + 1)'(BUFFER_DEPTH);

  state_t state_r, state_nxt;

  logic [15:0] max_speed_r;
  logic [13:0] half_len_r;
  logic [13:0] half_wid_r;

  logic [61:0] mem [BUFFER_DEPTH];
  logic [61:0] rd_data_r;
  logic        mem_we;
  logic [IW-1:0] mem_waddr;

  logic [BUFFER_DEPTH-1:0] valid_r, valid_nxt;

  logic [14:0] x_r, x_nxt;
  logic [14:0] y_r, y_nxt;
  logic [31:0] t_r, t_nxt;

  logic [IW:0]   scan_idx_r, scan_idx_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;

  logic          found_r, found_nxt;
  logic [IW-1:0] oidx_r, oidx_nxt;
  logic [31:0]   ostamp_r, ostamp_nxt;
  logic [14:0]   ox_r, ox_nxt;
  logic [14:0]   oy_r, oy_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [15:0] adx_r, adx_nxt;
  logic [15:0] ady_r, ady_nxt;
  logic [31:0] dt_r, dt_nxt;

  logic [3:0]  mstep_r, mstep_nxt;
  logic        pvld_r, pvld_nxt;
  mul_op_t     pop_r, pop_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [47:0] vd_r, vd_nxt;
  logic [31:0] dd_r, dd_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  logic [7:0] out_tdata_r, out_tdata_nxt;

  logic [14:0] ax, ay;
  logic        in_field, stale;
  logic [15:0] dx, dy;
  logic [31:0] opa, opb;
  logic [ACC_W-1:0] prod_ext;
  logic [2:0]  status;
  logic [CW+4:0] cnt_wide;
  mul_op_t     issue_op;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = out_tdata_r;

  assign ax = x_r[14] ? (~x_r + 15'd1) : x_r;
  assign ay = y_r[14] ? (~y_r + 15'd1) : y_r;
  assign in_field = (ax <= {1'b0, half_len_r}) && (ay <= {1'b0, half_wid_r});
  assign stale = (t_r <= ostamp_r);
  assign dx = {x_r[14], x_r} - {ox_r[14], ox_r};
  assign dy = {y_r[14], y_r} - {oy_r[14], oy_r};
  assign issue_op = mul_op_t'(mstep_r[2:0]);
  assign prod_ext = {{(ACC_W - 64){1'b0}}, prod_r};

  always_comb begin
    case (issue_op)
      OP_VD: begin
        opa = {16'd0, max_speed_r};
        opb = dt_r;
      end
      OP_DX: begin
        opa = {16'd0, adx_r};
        opb = {16'd0, adx_r};
      end
      OP_DY: begin
        opa = {16'd0, ady_r};
        opb = {16'd0, ady_r};
      end
      OP_LL: begin
        opa = vd_r[31:0];
        opb = vd_r[31:0];
      end
      OP_LH: begin
        opa = vd_r[31:0];
        opb = {16'd0, vd_r[47:32]};
      end
      OP_HH: begin
        opa = {16'd0, vd_r[47:32]};
        opb = {16'd0, vd_r[47:32]};
      end
      OP_KL: begin
        opa = dd_r;
        opb = TERA_LO;
      end
      OP_KH: begin
        opa = dd_r;
        opb = TERA_HI;
      end
      default: begin
        opa = 32'd0;
        opb = 32'd0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    t_nxt          = t_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    found_nxt      = found_r;
    oidx_nxt       = oidx_r;
    ostamp_nxt     = ostamp_r;
    ox_nxt         = ox_r;
    oy_nxt         = oy_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    cnt_nxt        = cnt_r;
    adx_nxt        = adx_r;
    ady_nxt        = ady_r;
    dt_nxt         = dt_r;
    mstep_nxt      = mstep_r;
    pvld_nxt       = 1'b0;
    pop_nxt        = pop_r;
    prod_nxt       = prod_r;
    vd_nxt         = vd_r;
    dd_nxt         = dd_r;
    acc_nxt        = acc_r;
    out_tdata_nxt  = out_tdata_r;
    mem_we         = 1'b0;
    mem_waddr      = free_idx_r;
    status         = STAT_OUTSIDE;
    cnt_wide       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          x_nxt          = in_tdata[14:0];
          y_nxt          = in_tdata[29:15];
          t_nxt          = in_tdata[61:30];
          scan_idx_nxt   = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          cnt_nxt        = '0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx_r != SCAN_END) begin
          scan_idx_nxt = scan_idx_r + (IW + 1)'(1);
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r[IW-1:0];
        end else begin
          state_nxt = ST_CHECK;
        end
        if (cmp_vld_r) begin
          if (valid_r[cmp_idx_r]) begin
            cnt_nxt = cnt_r + CW'(1);
            if (!found_r || (rd_data_r[61:30] < ostamp_r)) begin
              found_nxt  = 1'b1;
              oidx_nxt   = cmp_idx_r;
              ostamp_nxt = rd_data_r[61:30];
              ox_nxt     = rd_data_r[14:0];
              oy_nxt     = rd_data_r[29:15];
            end
          end else if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
        end
      end
      ST_CHECK: begin
        adx_nxt   = dx[15] ? (~dx + 16'd1) : dx;
        ady_nxt   = dy[15] ? (~dy + 16'd1) : dy;
        dt_nxt    = t_r - ostamp_r;
        mstep_nxt = '0;
        if (in_field && found_r && !stale) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_MUL: begin
        if (mstep_r != MUL_STEPS) begin
          prod_nxt  = opa * opb;
          pop_nxt   = issue_op;
          pvld_nxt  = 1'b1;
          mstep_nxt = mstep_r + 4'd1;
        end else begin
          state_nxt = ST_DECIDE;
        end
        if (pvld_r) begin
          case (pop_r)
            OP_VD: vd_nxt  = prod_r[47:0];
            OP_DX: dd_nxt  = prod_r[31:0];
            OP_DY: dd_nxt  = dd_r + prod_r[31:0];
            OP_LL: acc_nxt = prod_ext;
            OP_LH: acc_nxt = acc_r + (prod_ext << 33);
            OP_HH: acc_nxt = acc_r + (prod_ext << 64);
            OP_KL: acc_nxt = acc_r - prod_ext;
            OP_KH: acc_nxt = acc_r - (prod_ext << 32);
            default: acc_nxt = acc_r;
          endcase
        end
      end
      ST_DECIDE: begin
        if (!in_field) begin
          status = STAT_OUTSIDE;
        end else if (!found_r) begin
          status               = STAT_EMPTY;
          mem_we               = 1'b1;
          mem_waddr            = free_idx_r;
          valid_nxt[free_idx_r] = 1'b1;
          cnt_nxt              = cnt_r + CW'(1);
        end else if (stale) begin
          status = STAT_STALE;
        end else if (acc_r[ACC_W-1]) begin
          status            = STAT_NOISE;
          valid_nxt[oidx_r] = 1'b0;
          cnt_nxt           = cnt_r - CW'(1);
        end else if (free_found_r) begin
          status               = STAT_STORED;
          mem_we               = 1'b1;
          mem_waddr            = free_idx_r;
          valid_nxt[free_idx_r] = 1'b1;
          cnt_nxt              = cnt_r + CW'(1);
        end else begin
          status    = STAT_STORED;
          mem_we    = 1'b1;
          mem_waddr = oidx_r;
        end
        cnt_wide      = {5'd0, cnt_nxt};
        out_tdata_nxt = {cnt_wide[4:0], status};
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= {t_r, y_r, x_r};
    end
    rd_data_r <= mem[scan_idx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cmp_vld_r   <= 1'b0;
      pvld_r      <= 1'b0;
      max_speed_r <= RST_MAX_SPEED;
      half_len_r  <= RST_HALF_LENGTH;
      half_wid_r  <= RST_HALF_WIDTH;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      pvld_r    <= pvld_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_MAX_SPEED:   max_speed_r <= cfg_wdata;
          REG_HALF_LENGTH: half_len_r  <= cfg_wdata[13:0];
          REG_HALF_WIDTH:  half_wid_r  <= cfg_wdata[13:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    t_r          <= t_nxt;
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    found_r      <= found_nxt;
    oidx_r       <= oidx_nxt;
    ostamp_r     <= ostamp_nxt;
    ox_r         <= ox_nxt;
    oy_r         <= oy_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    cnt_r        <= cnt_nxt;
    adx_r        <= adx_nxt;
    ady_r        <= ady_nxt;
    dt_r         <= dt_nxt;
    mstep_r      <= mstep_nxt;
    pop_r        <= pop_nxt;
    prod_r       <= prod_nxt;
    vd_r         <= vd_nxt;
    dd_r         <= dd_nxt;
    acc_r        <= acc_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

endmodule

`default_nettype wire
